FILE: rtl/packed_pixel_unpack_rotate_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef PACKED_PIXEL_UNPACK_ROTATE_UNIT_DEFINES_SVH
`define PACKED_PIXEL_UNPACK_ROTATE_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define PPUR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ppur: same-cycle check failed");

// Next-cycle implication, off while reset is low.
`define PPUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ppur: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define PPUR_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ppur: reset check failed");

`endif

FILE: rtl/ppur_pkg.sv
package ppur_pkg;

    localparam int ADDR_W       = 20;
    localparam int COLOR_W      = 32;
    localparam int RGB_W        = 24;
    localparam int DIM_REG_W    = 11;
    localparam int BYTE_W       = 8;
    localparam int PIX_PER_BYTE = 8;
    localparam int IDX_W        = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_PIX_FMT         = 3'd0;
    localparam logic [2:0] REG_ROTATION        = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH     = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_FG_COLOR        = 3'd4;
    localparam logic [2:0] REG_BG_COLOR        = 3'd5;

    localparam logic [1:0] FMT_MONO = 2'd0;
    localparam logic [1:0] FMT_GRAY = 2'd1;
    localparam logic [1:0] FMT_TILE = 2'd2;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX_GRAY = 3'd3;
    localparam logic [IDX_W-1:0] LAST_IDX_FULL = 3'd7;

    localparam logic [7:0]           ALPHA_OPAQUE = 8'hFF;
    localparam logic [COLOR_W-1:0]   GRAY_TABLE [4] = '{
        32'hFFFFFFFF, 32'hFFAAAAAA, 32'hFF555555, 32'hFF000000
    };

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 11'd1024;
    localparam logic [RGB_W-1:0]     FG_RESET  = 24'h000000;
    localparam logic [RGB_W-1:0]     BG_RESET  = 24'hFFFFFF;

    typedef enum logic [1:0] {
        MODE_MONO,
        MODE_GRAY,
        MODE_TILE
    } t_mode;

    typedef struct packed {
        logic [1:0]           pix_fmt;
        logic [1:0]           rotation_quarter;
        logic [DIM_REG_W-1:0] frame_width;
        logic [DIM_REG_W-1:0] frame_height;
        logic [RGB_W-1:0]     fg_color;
        logic [RGB_W-1:0]     bg_color;
    } t_cfg;

    // one unpacked byte: a 2-bit level per pixel slot
    typedef struct packed {
        logic [PIX_PER_BYTE-1:0][1:0] lvl;
        logic [IDX_W-1:0]             last_idx;
        logic                         frame_start;
        t_mode                        mode;
    } t_entry;

endpackage

FILE: rtl/ppur_front.sv
module ppur_front (
    input  logic [1:0]                  i_pix_fmt,
    input  logic                        i_in_valid,
    input  logic [ppur_pkg::BYTE_W-1:0] i_wire_byte,
    input  logic                        i_frame_start,
    input  logic                        i_q_full,
    output logic                        o_in_ready,
    output logic                        o_push,
    output ppur_pkg::t_entry            o_entry
);

    ppur_pkg::t_mode                              mode;
    logic [ppur_pkg::PIX_PER_BYTE-1:0][1:0]       gray_lvl;
    logic [ppur_pkg::PIX_PER_BYTE-1:0][1:0]       bit_lvl;

    always_comb begin
        case (i_pix_fmt)
            ppur_pkg::FMT_MONO: mode = ppur_pkg::MODE_MONO;
            ppur_pkg::FMT_GRAY: mode = ppur_pkg::MODE_GRAY;
            ppur_pkg::FMT_TILE: mode = ppur_pkg::MODE_TILE;
            default:            mode = ppur_pkg::MODE_MONO;
        endcase
    end

    // gray: bit pairs MSB first; mono/tile: single bits MSB first
    always_comb begin
        gray_lvl = '0;
        for (int i = 0; i < ppur_pkg::PIX_PER_BYTE / 2; i++) begin
            gray_lvl[i] = i_wire_byte[ppur_pkg::BYTE_W-1-2*i -: 2];
        end
        for (int i = 0; i < ppur_pkg::PIX_PER_BYTE; i++) begin
            bit_lvl[i] = {1'b0, i_wire_byte[ppur_pkg::BYTE_W-1-i]};
        end
    end

    always_comb begin
        o_entry             = '0;
        o_entry.mode        = mode;
        o_entry.frame_start = i_frame_start;
        if (mode == ppur_pkg::MODE_GRAY) begin
            o_entry.lvl      = gray_lvl;
            o_entry.last_idx = ppur_pkg::LAST_IDX_GRAY;
        end else begin
            o_entry.lvl      = bit_lvl;
            o_entry.last_idx = ppur_pkg::LAST_IDX_FULL;
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

FILE: rtl/ppur_queue.sv
module ppur_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ppur_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output ppur_pkg::t_entry o_entry
);

    localparam int DEPTH = ppur_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppur_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

endmodule

FILE: rtl/ppur_back.sv
module ppur_back #(
    parameter int MAX_DIM = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ppur_pkg::t_cfg                 i_cfg,
    input  logic                           i_q_valid,
    input  ppur_pkg::t_entry               i_q_entry,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ppur_pkg::ADDR_W-1:0]    o_pixel_address,
    output logic [ppur_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic                           o_last_of_byte,
    output logic                           o_frame_done
);

    localparam int PW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int XW    = DW + 1;
    localparam int PRODW = PW + DW;
    localparam int SUMW  = PRODW + 1;
    localparam int IW    = ppur_pkg::IDX_W;

    // effective frame and tile grid sizes
    logic [DW-1:0] w_dim, h_dim, gw_dim, gh_dim, w_dn, h_dn;

    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w_dim = DW'(1);
        end else if (32'(i_cfg.frame_width) > 32'(MAX_DIM)) begin
            w_dim = DW'(MAX_DIM);
        end else begin
            w_dim = DW'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            h_dim = DW'(1);
        end else if (32'(i_cfg.frame_height) > 32'(MAX_DIM)) begin
            h_dim = DW'(MAX_DIM);
        end else begin
            h_dim = DW'(i_cfg.frame_height);
        end
        w_dn   = w_dim & ~DW'(3);
        h_dn   = h_dim & ~DW'(1);
        gw_dim = (w_dn < DW'(4)) ? DW'(4) : w_dn;
        gh_dim = (h_dn < DW'(2)) ? DW'(2) : h_dn;
    end

    // sequencer state
    logic             r_busy;
    ppur_pkg::t_entry r_ent;
    logic [IW-1:0]    r_idx;
    logic [PW-1:0]    r_col, r_row;

    // stage A: rotation terms and colour
    logic                          r_a_valid;
    logic [PW-1:0]                 r_a_row_term, r_a_col_term;
    logic [DW-1:0]                 r_a_mul;
    logic [ppur_pkg::COLOR_W-1:0]  r_a_color;
    logic                          r_a_last, r_a_done;

    // output register
    logic                          r_o_valid;
    logic [ppur_pkg::ADDR_W-1:0]   r_o_addr;
    logic [ppur_pkg::COLOR_W-1:0]  r_o_color;
    logic                          r_o_last, r_o_done;

    logic          is_tile, out_adv, a_take, step;
    logic [PW-1:0] base_col, base_row, cur_col, cur_row;
    logic          oog;

    always_comb begin
        is_tile  = (r_ent.mode == ppur_pkg::MODE_TILE);
        base_col = r_ent.frame_start ? '0 : r_col;
        base_row = r_ent.frame_start ? '0 : r_row;
        if (is_tile) begin
            oog = (XW'(base_col) >= XW'(gw_dim)) || (XW'(base_row) >= XW'(gh_dim));
        end else begin
            oog = (XW'(base_col) >= XW'(w_dim)) || (XW'(base_row) >= XW'(h_dim));
        end
        if (r_idx == '0) begin
            cur_col = oog ? '0 : base_col;
            cur_row = oog ? '0 : base_row;
        end else begin
            cur_col = r_col;
            cur_row = r_row;
        end
    end

    // mono / gray: one pixel a step, raster walk
    logic [XW-1:0] m_col_inc, m_row_inc;
    logic          m_col_wrap, m_row_wrap, m_end;
    logic [PW-1:0] m_next_col, m_next_row;

    always_comb begin
        m_col_inc  = XW'(cur_col) + XW'(1);
        m_row_inc  = XW'(cur_row) + XW'(1);
        m_col_wrap = (m_col_inc >= XW'(w_dim));
        m_row_wrap = m_col_wrap && (m_row_inc >= XW'(h_dim));
        m_next_col = m_col_wrap ? '0 : PW'(m_col_inc);
        if (!m_col_wrap) begin
            m_next_row = cur_row;
        end else if (m_row_wrap) begin
            m_next_row = '0;
        end else begin
            m_next_row = PW'(m_row_inc);
        end
        m_end = m_row_wrap || (r_idx == r_ent.last_idx);
    end

    // tile: 4x2 pixels around a fixed base
    logic [3:0]    t_col_ok;
    logic [1:0]    t_row_ok;
    logic [7:0]    t_emit;
    logic          t_later;
    logic [XW-1:0] t_x, t_y, t_col4, t_row2;
    logic          t_col_wrap, t_row_wrap;
    logic [PW-1:0] t_next_col, t_next_row;

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            t_col_ok[p] = (XW'(cur_col) + XW'(p)) < XW'(w_dim);
        end
        t_row_ok[0] = XW'(cur_row) < XW'(h_dim);
        t_row_ok[1] = (XW'(cur_row) + XW'(1)) < XW'(h_dim);
        t_later = 1'b0;
        for (int j = 0; j < ppur_pkg::PIX_PER_BYTE; j++) begin
            t_emit[j] = t_col_ok[j >> 1] && t_row_ok[j & 1];
            if (IW'(j) > r_idx) begin
                t_later = t_later | t_emit[j];
            end
        end
        t_x        = XW'(cur_col) + XW'(r_idx[IW-1:1]);
        t_y        = XW'(cur_row) + XW'(r_idx[0]);
        t_col4     = XW'(cur_col) + XW'(4);
        t_row2     = XW'(cur_row) + XW'(2);
        t_col_wrap = (t_col4 >= XW'(gw_dim));
        t_row_wrap = t_col_wrap && (t_row2 >= XW'(gh_dim));
        t_next_col = t_col_wrap ? '0 : PW'(t_col4);
        if (!t_col_wrap) begin
            t_next_row = cur_row;
        end else if (t_row_wrap) begin
            t_next_row = '0;
        end else begin
            t_next_row = PW'(t_row2);
        end
    end

    // per-step selection
    logic          emit, byte_end, wrapped;
    logic [PW-1:0] px_x, px_y, next_col, next_row;

    always_comb begin
        if (is_tile) begin
            px_x     = PW'(t_x);
            px_y     = PW'(t_y);
            emit     = t_emit[r_idx];
            byte_end = !t_later;
            wrapped  = t_row_wrap;
            next_col = byte_end ? t_next_col : cur_col;
            next_row = byte_end ? t_next_row : cur_row;
        end else begin
            px_x     = cur_col;
            px_y     = cur_row;
            emit     = 1'b1;
            byte_end = m_end;
            wrapped  = m_row_wrap;
            next_col = m_next_col;
            next_row = m_next_row;
        end
    end

    // rotation: address = row_term * mul + col_term
    logic [DW-1:0] x_flip, y_flip;
    logic [PW-1:0] row_term, col_term;
    logic [DW-1:0] mul_term;

    always_comb begin
        x_flip = w_dim - DW'(1) - DW'(px_x);
        y_flip = h_dim - DW'(1) - DW'(px_y);
        case (i_cfg.rotation_quarter)
            ppur_pkg::ROT_0: begin
                row_term = px_y;
                mul_term = w_dim;
                col_term = px_x;
            end
            ppur_pkg::ROT_90: begin
                row_term = px_x;
                mul_term = h_dim;
                col_term = PW'(y_flip);
            end
            ppur_pkg::ROT_180: begin
                row_term = PW'(y_flip);
                mul_term = w_dim;
                col_term = PW'(x_flip);
            end
            ppur_pkg::ROT_270: begin
                row_term = PW'(x_flip);
                mul_term = h_dim;
                col_term = px_y;
            end
            default: begin
                row_term = px_y;
                mul_term = w_dim;
                col_term = px_x;
            end
        endcase
    end

    logic [1:0]                   lvl;
    logic [ppur_pkg::COLOR_W-1:0] color;

    always_comb begin
        lvl = r_ent.lvl[r_idx];
        if (r_ent.mode == ppur_pkg::MODE_GRAY) begin
            color = ppur_pkg::GRAY_TABLE[lvl];
        end else begin
            color = {ppur_pkg::ALPHA_OPAQUE, lvl[0] ? i_cfg.fg_color : i_cfg.bg_color};
        end
    end

    // handshake through the two stages
    always_comb begin
        out_adv = !r_o_valid || i_out_ready;
        a_take  = !r_a_valid || out_adv;
        step    = r_busy && a_take;
        o_pop   = i_q_valid && (!r_busy || (step && byte_end));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (step && byte_end) begin
                r_busy <= 1'b0;
            end else if (step) begin
                r_idx <= r_idx + IW'(1);
            end
            if (step) begin
                r_col <= next_col;
                r_row <= next_row;
            end
            if (a_take) begin
                r_a_valid <= step && emit;
            end
            if (out_adv) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    logic [PRODW-1:0] a_prod;
    logic [SUMW-1:0]  a_sum;

    assign a_prod = r_a_row_term * r_a_mul;
    assign a_sum  = SUMW'(a_prod) + SUMW'(r_a_col_term);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_q_entry;
        end
        if (step) begin
            r_a_row_term <= row_term;
            r_a_col_term <= col_term;
            r_a_mul      <= mul_term;
            r_a_color    <= color;
            r_a_last     <= byte_end;
            r_a_done     <= byte_end && wrapped;
        end
        if (out_adv) begin
            r_o_addr  <= ppur_pkg::ADDR_W'(a_sum);
            r_o_color <= r_a_color;
            r_o_last  <= r_a_last;
            r_o_done  <= r_a_done;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_pixel_address = r_o_addr;
    assign o_pixel_color   = r_o_color;
    assign o_last_of_byte  = r_o_last;
    assign o_frame_done    = r_o_done;

endmodule

FILE: rtl/packed_pixel_unpack_rotate_unit.sv
// Packed framebuffer pixel unpacker with rotated output addressing.
// Input channel (i_in_valid / o_in_ready): one packed byte per transfer plus
//   a frame_start flag that puts the position counters back to the origin.
// Output channel (o_out_valid / i_out_ready): one pixel per transfer, with
//   its ARGB8888 colour, its address in the rotated frame, a last-of-byte
//   flag and a frame-done flag on the pixel that closes the frame.
// APB port: format, rotation, width, height, fg and bg colour at 4*index;
//   pready is tied high, writes land on the access cycle.
// With the pipe empty, the first pixel of a byte passes through the queue,
//   the sequencer, the address stage and the output register.
// Throughput (set by the pixel sequencer and its single address multiplier):
//   one step per cycle while the output is not stalled; a byte has 8 pixel
//   slots in mono and tile format, 4 in gray; tile bytes end early when their
//   trailing pixels fall off the frame, an off-frame tile pixel before the
//   last one still takes a step with no output; mono/gray stop at frame wrap.
// A two-entry queue lets bytes be taken while earlier pixels are still out.
// Reset (synchronous, active low) empties the queue and pipe, clears the
//   position counters and loads the register defaults.
// When the receiver stalls the output register holds, the sequencer stops
//   and the queue fills, after which o_in_ready drops.
module packed_pixel_unpack_rotate_unit #(
    parameter int MAX_DIM = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // byte input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ppur_pkg::BYTE_W-1:0]        i_wire_byte,
    input  logic                               i_frame_start,
    // pixel output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ppur_pkg::ADDR_W-1:0]        o_pixel_address,
    output logic [ppur_pkg::COLOR_W-1:0]       o_pixel_color,
    output logic                               o_last_of_byte,
    output logic                               o_frame_done,
    // APB register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppur_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ppur_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ppur_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [1:0]                       r_pix_fmt;
    logic [1:0]                       r_rotation;
    logic [ppur_pkg::DIM_REG_W-1:0]   r_frame_width;
    logic [ppur_pkg::DIM_REG_W-1:0]   r_frame_height;
    logic [ppur_pkg::RGB_W-1:0]       r_fg_color;
    logic [ppur_pkg::RGB_W-1:0]       r_bg_color;
    logic                             cfg_wr;
    logic [2:0]                       reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ppur_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_fmt      <= ppur_pkg::FMT_MONO;
            r_rotation     <= ppur_pkg::ROT_0;
            r_frame_width  <= ppur_pkg::DIM_RESET;
            r_frame_height <= ppur_pkg::DIM_RESET;
            r_fg_color     <= ppur_pkg::FG_RESET;
            r_bg_color     <= ppur_pkg::BG_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                ppur_pkg::REG_PIX_FMT:      r_pix_fmt      <= pwdata[1:0];
                ppur_pkg::REG_ROTATION:     r_rotation     <= pwdata[1:0];
                ppur_pkg::REG_FRAME_WIDTH:
                    r_frame_width  <= pwdata[ppur_pkg::DIM_REG_W-1:0];
                ppur_pkg::REG_FRAME_HEIGHT:
                    r_frame_height <= pwdata[ppur_pkg::DIM_REG_W-1:0];
                ppur_pkg::REG_FG_COLOR:     r_fg_color <= pwdata[ppur_pkg::RGB_W-1:0];
                ppur_pkg::REG_BG_COLOR:     r_bg_color <= pwdata[ppur_pkg::RGB_W-1:0];
                default: ;
            endcase
        end
    end

    // read-back, zero-extended
    always_comb begin
        case (reg_idx)
            ppur_pkg::REG_PIX_FMT:      prdata = ppur_pkg::APB_DATA_W'(r_pix_fmt);
            ppur_pkg::REG_ROTATION:     prdata = ppur_pkg::APB_DATA_W'(r_rotation);
            ppur_pkg::REG_FRAME_WIDTH:  prdata = ppur_pkg::APB_DATA_W'(r_frame_width);
            ppur_pkg::REG_FRAME_HEIGHT: prdata = ppur_pkg::APB_DATA_W'(r_frame_height);
            ppur_pkg::REG_FG_COLOR:     prdata = ppur_pkg::APB_DATA_W'(r_fg_color);
            ppur_pkg::REG_BG_COLOR:     prdata = ppur_pkg::APB_DATA_W'(r_bg_color);
            default:                    prdata = '0;
        endcase
    end

    ppur_pkg::t_cfg cfg;

    always_comb begin
        cfg.pix_fmt          = r_pix_fmt;
        cfg.rotation_quarter = r_rotation;
        cfg.frame_width      = r_frame_width;
        cfg.frame_height     = r_frame_height;
        cfg.fg_color         = r_fg_color;
        cfg.bg_color         = r_bg_color;
    end

    // ---------------------------------------------------------------
    // Front: take bytes, unpack into per-pixel levels
    // ---------------------------------------------------------------
    logic             q_full, q_push, q_pop, q_valid;
    ppur_pkg::t_entry front_entry, q_entry;

    ppur_front u_front (
        .i_pix_fmt      (r_pix_fmt),
        .i_in_valid     (i_in_valid),
        .i_wire_byte    (i_wire_byte),
        .i_frame_start  (i_frame_start),
        .i_q_full       (q_full),
        .o_in_ready     (o_in_ready),
        .o_push         (q_push),
        .o_entry        (front_entry)
    );

    // short queue decoupling byte intake from pixel output
    ppur_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // ---------------------------------------------------------------
    // Back: position walk, colour, rotated address, output register
    // ---------------------------------------------------------------
    ppur_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q_valid       (q_valid),
        .i_q_entry       (q_entry),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_of_byte  (o_last_of_byte),
        .o_frame_done    (o_frame_done)
    );

endmodule

FILE: rtl/ppur_checker.sv
`include "packed_pixel_unpack_rotate_unit_defines.svh"

module ppur_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [ppur_pkg::ADDR_W-1:0]      i_pixel_address,
    input logic [ppur_pkg::COLOR_W-1:0]     i_pixel_color,
    input logic                             i_last_of_byte,
    input logic                             i_frame_done
);

    // a stalled pixel stays offered
    `PPUR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // and keeps its payload
    `PPUR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_pixel_address) && $stable(i_pixel_color) && $stable(i_last_of_byte) && $stable(i_frame_done))

    // the frame always closes on the last pixel of a byte
    `PPUR_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n, i_out_valid && i_frame_done, i_last_of_byte)

    // reset leaves an empty pipe that takes bytes
    `PPUR_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !i_out_valid && i_in_ready)

endmodule

bind packed_pixel_unpack_rotate_unit ppur_checker u_ppur_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (o_in_ready),
    .i_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .i_pixel_address (o_pixel_address),
    .i_pixel_color   (o_pixel_color),
    .i_last_of_byte  (o_last_of_byte),
    .i_frame_done    (o_frame_done)
);

FILE: verif/tb_packed_pixel_unpack_rotate_unit.sv
module tb_packed_pixel_unpack_rotate_unit;

    // Format code 3 has no name in the package; it must behave as mono.
    localparam logic [1:0] FMT_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RANDOM_BYTES = 150;

    // One expected pixel transfer on the output channel.
    typedef struct {
        logic [ppur_pkg::ADDR_W-1:0]  addr;
        logic [ppur_pkg::COLOR_W-1:0] color;
        logic                         last;
        logic                         done;
    } t_pixel;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [ppur_pkg::BYTE_W-1:0]     i_wire_byte;
    logic                            i_frame_start;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [ppur_pkg::ADDR_W-1:0]     o_pixel_address;
    logic [ppur_pkg::COLOR_W-1:0]    o_pixel_color;
    logic                            o_last_of_byte;
    logic                            o_frame_done;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ppur_pkg::APB_ADDR_W-1:0] paddr;
    logic [ppur_pkg::APB_DATA_W-1:0] pwdata;
    logic [ppur_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Shadow of the register file and of the source position counters.
    ppur_pkg::t_cfg regs;
    int             src_col;
    int             src_row;
    t_pixel         pending_pixels[$];

    // When set, neither side idles: gives a stretch at full rate.
    bit steady;

    int fail_count;
    int bytes_taken;
    int pixels_checked;
    int frames_closed;
    int settings_used;
    int random_bytes;
    int cycle_count;

    packed_pixel_unpack_rotate_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_wire_byte     (i_wire_byte),
        .i_frame_start   (i_frame_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_of_byte  (o_last_of_byte),
        .o_frame_done    (o_frame_done),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Hard stop in case the block hangs on either channel.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d pixels outstanding", $time,
                     pending_pixels.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: stalls at random, about 28 times in 100, unless in a steady stretch.
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 28);
    end

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------

    // Zero counts as 1, anything above the maximum as the maximum.
    function automatic int clamp_dim(input logic [ppur_pkg::DIM_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > 1024) return 1024;
        return int'(v);
    endfunction

    // Linear index of source pixel (x, y) in the turned frame.
    function automatic logic [ppur_pkg::ADDR_W-1:0] rot_addr(input int x, input int y,
                                                             input int w, input int h);
        int a;
        case (regs.rotation_quarter)
            ppur_pkg::ROT_0:   a = y * w + x;
            ppur_pkg::ROT_90:  a = x * h + (h - 1 - y);
            ppur_pkg::ROT_180: a = (h - 1 - y) * w + (w - 1 - x);
            default:           a = (w - 1 - x) * h + y;
        endcase
        return a[ppur_pkg::ADDR_W-1:0];
    endfunction

    function automatic logic [ppur_pkg::COLOR_W-1:0] bit_argb(input logic on);
        return {8'hFF, on ? regs.fg_color : regs.bg_color};
    endfunction

    // Gray levels run from white down to black.
    function automatic logic [ppur_pkg::COLOR_W-1:0] gray_argb(input logic [1:0] level);
        case (level)
            2'd0:    return 32'hFFFFFFFF;
            2'd1:    return 32'hFFAAAAAA;
            2'd2:    return 32'hFF555555;
            default: return 32'hFF000000;
        endcase
    endfunction

    function automatic void queue_pixel(input logic [ppur_pkg::ADDR_W-1:0] a,
                                        input logic [ppur_pkg::COLOR_W-1:0] c);
        t_pixel px;
        px.addr  = a;
        px.color = c;
        px.last  = 1'b0;
        px.done  = 1'b0;
        pending_pixels.push_back(px);
    endfunction

    // Expands one accepted byte into its pixels and advances the counters.
    function automatic void unpack_byte(input logic [ppur_pkg::BYTE_W-1:0] b,
                                        input logic fs);
        int  w, h, gw, gh, x, y, cnt, first;
        bit  wrapped;
        logic [1:0] lvl;
        w       = clamp_dim(regs.frame_width);
        h       = clamp_dim(regs.frame_height);
        wrapped = 1'b0;
        first   = pending_pixels.size();
        if (fs) begin
            src_col = 0;
            src_row = 0;
        end
        if (regs.pix_fmt == ppur_pkg::FMT_TILE) begin
            // Tile grid is trimmed to whole tiles, at least one tile.
            gw = w & ~3;
            gh = h & ~1;
            if (gw < 4) gw = 4;
            if (gh < 2) gh = 2;
            if (src_col >= gw || src_row >= gh) begin
                src_col = 0;
                src_row = 0;
            end
            for (int i = 0; i < 8; i++) begin
                x = src_col + i / 2;
                y = src_row + i % 2;
                if (x < w && y < h)
                    queue_pixel(rot_addr(x, y, w, h), bit_argb(b[7-i]));
            end
            src_col += 4;
            if (src_col >= gw) begin
                src_col = 0;
                src_row += 2;
                if (src_row >= gh) begin
                    src_row = 0;
                    wrapped = 1'b1;
                end
            end
        end else begin
            cnt = (regs.pix_fmt == ppur_pkg::FMT_GRAY) ? 4 : 8;
            if (src_col >= w || src_row >= h) begin
                src_col = 0;
                src_row = 0;
            end
            // Raster order; whatever is left of the byte after the frame end is dropped.
            for (int i = 0; i < cnt && !wrapped; i++) begin
                if (regs.pix_fmt == ppur_pkg::FMT_GRAY) begin
                    lvl = b[7-2*i -: 2];
                    queue_pixel(rot_addr(src_col, src_row, w, h), gray_argb(lvl));
                end else begin
                    queue_pixel(rot_addr(src_col, src_row, w, h), bit_argb(b[7-i]));
                end
                src_col++;
                if (src_col >= w) begin
                    src_col = 0;
                    src_row++;
                    if (src_row >= h) begin
                        src_row = 0;
                        wrapped = 1'b1;
                    end
                end
            end
        end
        if (pending_pixels.size() > first) begin
            pending_pixels[pending_pixels.size()-1].last = 1'b1;
            pending_pixels[pending_pixels.size()-1].done = wrapped;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on each byte transfer, checks each pixel transfer.
    // Values read here are the ones present just before the edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : pixel_check
        t_pixel want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                unpack_byte(i_wire_byte, i_frame_start);
                bytes_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel addr %h colour %h", $time,
                             o_pixel_address, o_pixel_color);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (o_pixel_address !== want.addr) begin
                        $display("%0t: address expected %h actual %h", $time,
                                 want.addr, o_pixel_address);
                        fail_count++;
                    end
                    if (o_pixel_color !== want.color) begin
                        $display("%0t: colour expected %h actual %h", $time,
                                 want.color, o_pixel_color);
                        fail_count++;
                    end
                    if (o_last_of_byte !== want.last) begin
                        $display("%0t: last_of_byte expected %b actual %b", $time,
                                 want.last, o_last_of_byte);
                        fail_count++;
                    end
                    if (o_frame_done !== want.done) begin
                        $display("%0t: frame_done expected %b actual %b", $time,
                                 want.done, o_frame_done);
                        fail_count++;
                    end
                    if (want.done) frames_closed++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offers one byte; returns at the edge where it is transferred.
    task automatic push_byte(input logic [ppur_pkg::BYTE_W-1:0] b, input logic fs);
        while (!steady && $urandom_range(0, 99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_wire_byte   <= b;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drops valid, waits for every pixel, then lets the pipe settle.
    // The first edge lets the monitor book the last transfer.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic set_reg(input logic [2:0] idx,
                           input logic [ppur_pkg::APB_DATA_W-1:0] value);
        logic [ppur_pkg::APB_DATA_W-1:0] keep;
        logic [ppur_pkg::APB_DATA_W-1:0] seen;
        wait_drained();
        case (idx)
            ppur_pkg::REG_PIX_FMT, ppur_pkg::REG_ROTATION:
                keep = value & 32'h3;
            ppur_pkg::REG_FRAME_WIDTH, ppur_pkg::REG_FRAME_HEIGHT:
                keep = value & 32'h7FF;
            default:
                keep = value & 32'hFF_FFFF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register takes the value at this edge
        case (idx)
            ppur_pkg::REG_PIX_FMT:      regs.pix_fmt          = keep[1:0];
            ppur_pkg::REG_ROTATION:     regs.rotation_quarter = keep[1:0];
            ppur_pkg::REG_FRAME_WIDTH:  regs.frame_width      = keep[ppur_pkg::DIM_REG_W-1:0];
            ppur_pkg::REG_FRAME_HEIGHT: regs.frame_height     = keep[ppur_pkg::DIM_REG_W-1:0];
            ppur_pkg::REG_FG_COLOR:     regs.fg_color         = keep[ppur_pkg::RGB_W-1:0];
            default:                    regs.bg_color         = keep[ppur_pkg::RGB_W-1:0];
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        seen = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== keep) begin
            $display("%0t: register %0d read-back expected %h actual %h", $time,
                     idx, keep, seen);
            fail_count++;
        end
    endtask

    task automatic configure(input logic [1:0] fmt, input logic [1:0] rot,
                             input logic [ppur_pkg::DIM_REG_W-1:0] w,
                             input logic [ppur_pkg::DIM_REG_W-1:0] h);
        set_reg(ppur_pkg::REG_PIX_FMT, 32'(fmt));
        set_reg(ppur_pkg::REG_ROTATION, 32'(rot));
        set_reg(ppur_pkg::REG_FRAME_WIDTH, 32'(w));
        set_reg(ppur_pkg::REG_FRAME_HEIGHT, 32'(h));
        settings_used++;
    endtask

    task automatic set_colours(input logic [ppur_pkg::RGB_W-1:0] fg,
                               input logic [ppur_pkg::RGB_W-1:0] bg);
        set_reg(ppur_pkg::REG_FG_COLOR, 32'(fg));
        set_reg(ppur_pkg::REG_BG_COLOR, 32'(bg));
    endtask

    // Random frame size; unit biases towards whole tiles.
    function automatic logic [ppur_pkg::DIM_REG_W-1:0] pick_dim(input int unit);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 11'd1024;
            2:       return 11'($urandom_range(1025, 2047));
            3:       return 11'($urandom_range(1, 2047));
            4, 5, 6: return 11'($urandom_range(1, 12));
            default: return 11'(unit * $urandom_range(1, 4));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults after reset: mono, 1024 square, black on white.
    task automatic test_reset_defaults();
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
    endtask

    // 5x3 mono frame: the second byte crosses the frame end, its last bit drops.
    task automatic test_mono_frame_wrap();
        set_colours(24'hFFFFFF, 24'h000000);
        configure(ppur_pkg::FMT_MONO, ppur_pkg::ROT_90, 11'd5, 11'd3);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h5A, 1'b0);
        configure(ppur_pkg::FMT_MONO, ppur_pkg::ROT_270, 11'd5, 11'd3);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
    endtask

    // All four gray levels, frame end in the middle of the second byte.
    task automatic test_gray_levels();
        configure(ppur_pkg::FMT_GRAY, ppur_pkg::ROT_180, 11'd3, 11'd2);
        push_byte(8'h1B, 1'b1);
        push_byte(8'hE4, 1'b0);
    endtask

    // Full 8x4 tile frame, then a frame smaller than one tile.
    task automatic test_tiles();
        set_colours(24'h123456, 24'hABCDEF);
        configure(ppur_pkg::FMT_TILE, ppur_pkg::ROT_90, 11'd8, 11'd4);
        push_byte(8'hC3, 1'b1);
        push_byte(8'h3C, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);
        configure(ppur_pkg::FMT_TILE, ppur_pkg::ROT_0, 11'd2, 11'd1);
        push_byte(8'hFF, 1'b1);
    endtask

    // Zero sizes act as 1, oversize as the maximum; unused format code.
    task automatic test_size_clamp();
        configure(ppur_pkg::FMT_MONO, ppur_pkg::ROT_0, 11'd0, 11'd0);
        push_byte(8'h7F, 1'b1);
        configure(FMT_SPARE, ppur_pkg::ROT_270, 11'd2047, 11'd2047);
        push_byte(8'h96, 1'b1);
        push_byte(8'h69, 1'b0);
    endtask

    // Width shrunk mid-frame: the counters fall outside and restart.
    task automatic test_counter_restart();
        configure(ppur_pkg::FMT_MONO, ppur_pkg::ROT_0, 11'd16, 11'd2);
        push_byte(8'h55, 1'b1);
        configure(ppur_pkg::FMT_MONO, ppur_pkg::ROT_0, 11'd4, 11'd2);
        push_byte(8'hAA, 1'b0);
    endtask

    // Random settings per phase, mostly small frames so they wrap often.
    task automatic test_random_frames();
        int phase, len, sel;
        logic [1:0] fmt;
        phase = 0;
        while (random_bytes < RANDOM_BYTES) begin
            sel = $urandom_range(0, 9);
            fmt = (sel < 3) ? ppur_pkg::FMT_MONO :
                  (sel < 6) ? ppur_pkg::FMT_GRAY :
                  (sel < 9) ? ppur_pkg::FMT_TILE : FMT_SPARE;
            case ($urandom_range(0, 5))
                0:       set_colours(24'hFFFFFF, 24'h000000);
                1:       set_colours(24'h000000, 24'hFFFFFF);
                default: set_colours(24'($urandom), 24'($urandom));
            endcase
            configure(fmt, 2'($urandom_range(0, 3)),
                      pick_dim(fmt == ppur_pkg::FMT_TILE ? 4 : 1),
                      pick_dim(fmt == ppur_pkg::FMT_TILE ? 2 : 1));
            // one long phase at full rate on both sides
            steady = (phase == 2);
            len    = steady ? 30 : $urandom_range(6, 24);
            for (int i = 0; i < len; i++) begin
                push_byte(8'($urandom),
                          (i == 0) ? ($urandom_range(0, 9) < 7)
                                   : ($urandom_range(0, 99) < 8));
                random_bytes++;
            end
            steady = 1'b0;
            phase++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_wire_byte   = '0;
        i_frame_start = 1'b0;
        i_out_ready   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        steady        = 1'b0;
        fail_count    = 0;
        bytes_taken   = 0;
        pixels_checked = 0;
        frames_closed = 0;
        settings_used = 1;
        random_bytes  = 0;
        cycle_count   = 0;
        src_col       = 0;
        src_row       = 0;
        regs.pix_fmt          = ppur_pkg::FMT_MONO;
        regs.rotation_quarter = ppur_pkg::ROT_0;
        regs.frame_width      = ppur_pkg::DIM_RESET;
        regs.frame_height     = ppur_pkg::DIM_RESET;
        regs.fg_color         = ppur_pkg::FG_RESET;
        regs.bg_color         = ppur_pkg::BG_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_mono_frame_wrap();
        test_gray_levels();
        test_tiles();
        test_size_clamp();
        test_counter_restart();
        test_random_frames();

        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("Covered %0d bytes and %0d pixels over %0d register settings,",
                 bytes_taken, pixels_checked, settings_used);
        $display("all formats and rotations, %0d frames closed.", frames_closed);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ppur_pkg.sv
rtl/ppur_front.sv
rtl/ppur_queue.sv
rtl/ppur_back.sv
rtl/packed_pixel_unpack_rotate_unit.sv
rtl/ppur_checker.sv
verif/tb_packed_pixel_unpack_rotate_unit.sv
